@@ rtl/core/sdcs_pkg.sv @@
// Shared types and constants for the stick dead zone, calibration and scale block.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package sdcs_pkg;

  localparam int NumChannels = 4;
  localparam int ChanW       = 2;
  localparam int OpW         = 2;
  localparam int SampleW     = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 8;

  localparam logic [SampleW-1:0] ScaleTop      = 8'd127;
  localparam logic [SampleW-1:0] FullScaleRst  = 8'd255;
  localparam logic [SampleW-1:0] DeadbandRst   = 8'd0;
  localparam logic [NumChannels-1:0] FlipRst   = 4'd0;
  localparam logic [NumChannels-1:0] CenterRst = 4'd15;
  localparam logic [SampleW-1:0] BandLowRst    = 8'd255;
  localparam logic [SampleW-1:0] BandHighRst   = 8'd0;

  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = 1;
  localparam int QueueCntW   = 2;

  localparam int DivSteps    = 8;
  localparam int BitsPerStep = 2;
  localparam int StepW       = 3;
  localparam int DvdW        = 16;
  localparam int RemW        = 9;

  typedef enum logic [OpW-1:0] {
    OP_CALIBRATE = 2'd0,
    OP_CLOSE     = 2'd1,
    OP_CONVERT   = 2'd2,
    OP_IGNORE    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FULL_SCALE = 2'd0,
    CFG_DEADBAND   = 2'd1,
    CFG_FLIP_MASK  = 2'd2,
    CFG_CENTER     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic               div;
    logic [SampleW-1:0] num;
    logic [SampleW-1:0] den;
    logic [SampleW-1:0] mag;
    logic               neg;
    logic [ChanW-1:0]   ch;
  } job_t;

endpackage

`default_nettype wire

@@ rtl/core/sdcs_if.sv @@
// Channel interfaces for the input items, the results and the configuration writes.
// Depends on sdcs_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sdcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [sdcs_pkg::OpW-1:0]     op;
  logic [sdcs_pkg::ChanW-1:0]   channel;
  logic [sdcs_pkg::SampleW-1:0] sample;
  modport source (output valid, op, channel, sample, input ready);
  modport sink   (input valid, op, channel, sample, output ready);
endinterface

interface sdcs_out_if;
  logic                         valid;
  logic                         ready;
  logic [sdcs_pkg::SampleW-1:0] magnitude;
  logic                         negative;
  logic [sdcs_pkg::ChanW-1:0]   out_channel;
  modport source (output valid, magnitude, negative, out_channel, input ready);
  modport sink   (input valid, magnitude, negative, out_channel, output ready);
endinterface

interface sdcs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sdcs_pkg::CfgIdxW-1:0]  index;
  logic [sdcs_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sdcs_front.sv @@
// Front end: configuration registers, per-channel rest bands, item classification.
// Depends on sdcs_pkg and the channel interfaces in sdcs_if.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  sdcs_in_if.sink          in_i,
  sdcs_cfg_if.sink         cfg_i,
  input  wire logic        q_full_i,
  output sdcs_pkg::job_t   job_o,
  output logic             push_o
);

  logic [sdcs_pkg::SampleW-1:0]     full_scale_q;
  logic [sdcs_pkg::SampleW-1:0]     deadband_q;
  logic [sdcs_pkg::NumChannels-1:0] flip_q;
  logic [sdcs_pkg::NumChannels-1:0] center_q;
  logic [sdcs_pkg::SampleW-1:0]     band_low_q  [sdcs_pkg::NumChannels];
  logic [sdcs_pkg::SampleW-1:0]     band_high_q [sdcs_pkg::NumChannels];
  logic [sdcs_pkg::SampleW-1:0]     band_low_d;
  logic [sdcs_pkg::SampleW-1:0]     band_high_d;

  logic                         accept;
  logic                         chan_ok;
  sdcs_pkg::op_e                op;
  logic [sdcs_pkg::SampleW-1:0] v;
  logic [sdcs_pkg::SampleW-1:0] lo;
  logic [sdcs_pkg::SampleW-1:0] hi;
  logic [sdcs_pkg::SampleW:0]   hi_wide;

  assign in_i.ready  = !q_full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign op          = sdcs_pkg::op_e'(in_i.op);
  assign chan_ok     = 32'(in_i.channel) < 32'(sdcs_pkg::NumChannels);
  assign lo          = band_low_q[in_i.channel];
  assign hi          = band_high_q[in_i.channel];

  always_comb begin
    if (flip_q[in_i.channel]) begin
      v = (in_i.sample > full_scale_q) ? '0 : full_scale_q - in_i.sample;
    end else begin
      v = in_i.sample;
    end
  end

  always_comb begin
    band_low_d  = lo;
    band_high_d = hi;
    hi_wide     = {1'b0, hi} + {1'b0, deadband_q};
    unique case (op)
      sdcs_pkg::OP_CALIBRATE: begin
        if (v < lo) begin
          band_low_d = v;
        end
        if (v > hi) begin
          band_high_d = v;
        end
      end
      sdcs_pkg::OP_CLOSE: begin
        band_low_d  = (lo > deadband_q) ? lo - deadband_q : '0;
        band_high_d = (hi_wide > {1'b0, full_scale_q}) ? full_scale_q
                                                       : hi_wide[sdcs_pkg::SampleW-1:0];
      end
      sdcs_pkg::OP_CONVERT, sdcs_pkg::OP_IGNORE: begin
      end
    endcase
  end

  always_comb begin
    job_o     = '0;
    job_o.ch  = in_i.channel;
    job_o.mag = v;
    if (center_q[in_i.channel]) begin
      if (v >= lo && v <= hi) begin
        job_o.mag = '0;
      end else if (v > hi) begin
        if (full_scale_q <= hi) begin
          job_o.mag = sdcs_pkg::ScaleTop;
        end else begin
          job_o.div = 1'b1;
          job_o.num = v - hi;
          job_o.den = full_scale_q - hi;
        end
      end else begin
        job_o.div = 1'b1;
        job_o.num = lo - v;
        job_o.den = lo;
        job_o.neg = 1'b1;
      end
    end
  end

  assign push_o = accept && chan_ok && (op == sdcs_pkg::OP_CONVERT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= sdcs_pkg::FullScaleRst;
      deadband_q   <= sdcs_pkg::DeadbandRst;
      flip_q       <= sdcs_pkg::FlipRst;
      center_q     <= sdcs_pkg::CenterRst;
      for (int i = 0; i < sdcs_pkg::NumChannels; i++) begin
        band_low_q[i]  <= sdcs_pkg::BandLowRst;
        band_high_q[i] <= sdcs_pkg::BandHighRst;
      end
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (sdcs_pkg::cfg_idx_e'(cfg_i.index))
          sdcs_pkg::CFG_FULL_SCALE: full_scale_q <= cfg_i.data;
          sdcs_pkg::CFG_DEADBAND:   deadband_q   <= cfg_i.data;
          sdcs_pkg::CFG_FLIP_MASK:  flip_q       <= cfg_i.data[sdcs_pkg::NumChannels-1:0];
          sdcs_pkg::CFG_CENTER:     center_q     <= cfg_i.data[sdcs_pkg::NumChannels-1:0];
        endcase
      end
      if (accept && chan_ok) begin
        band_low_q[in_i.channel]  <= band_low_d;
        band_high_q[in_i.channel] <= band_high_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sdcs_fifo.sv @@
// Short job queue between the front end and the divider back end.
// Depends on sdcs_pkg for the job type and the queue depth.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire sdcs_pkg::job_t  job_i,
  input  wire logic            pop_i,
  output sdcs_pkg::job_t       job_o,
  output logic                 full_o,
  output logic                 empty_o
);

  sdcs_pkg::job_t                  mem_q [sdcs_pkg::QueueDepth];
  logic [sdcs_pkg::QueuePtrW-1:0]  wr_q, wr_d;
  logic [sdcs_pkg::QueuePtrW-1:0]  rd_q, rd_d;
  logic [sdcs_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                            do_push;
  logic                            do_pop;

  assign full_o  = cnt_q == sdcs_pkg::QueueCntW'(sdcs_pkg::QueueDepth);
  assign empty_o = cnt_q == '0;
  assign job_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sdcs_back.sv @@
// Back end: serial restoring divider for the rescale and the result register.
// Depends on sdcs_pkg and the result interface in sdcs_if.
`timescale 1ns / 1ps
`default_nettype none

module sdcs_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire sdcs_pkg::job_t  job_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  sdcs_out_if.source           out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e                          state_q;
  logic [sdcs_pkg::RemW-1:0]       rem_q, rem_d;
  logic [sdcs_pkg::DvdW-1:0]       dvd_q, dvd_d;
  logic [sdcs_pkg::DvdW-1:0]       quo_q, quo_d;
  logic [sdcs_pkg::SampleW-1:0]    den_q;
  logic [sdcs_pkg::StepW-1:0]      step_q;
  logic [sdcs_pkg::SampleW-1:0]    mag_q;
  logic                            neg_q;
  logic [sdcs_pkg::ChanW-1:0]      ch_q;
  logic [sdcs_pkg::DvdW-1:0]       dvd_init;
  logic [sdcs_pkg::RemW-1:0]       trial;

  assign pop_o = (state_q == ST_IDLE) && !empty_i;

  // The dividend is num * 127, formed as num * 128 - num.
  assign dvd_init = {1'b0, job_i.num, 7'b0} - {8'b0, job_i.num};

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    quo_d = quo_q;
    trial = '0;
    for (int b = 0; b < sdcs_pkg::BitsPerStep; b++) begin
      trial = {rem_d[sdcs_pkg::RemW-2:0], dvd_d[sdcs_pkg::DvdW-1]};
      dvd_d = {dvd_d[sdcs_pkg::DvdW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_d[sdcs_pkg::DvdW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_d[sdcs_pkg::DvdW-2:0], 1'b0};
      end
    end
  end

  assign out_o.valid       = state_q == ST_OUT;
  assign out_o.magnitude   = mag_q;
  assign out_o.negative    = neg_q;
  assign out_o.out_channel = ch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      rem_q   <= '0;
      dvd_q   <= '0;
      quo_q   <= '0;
      den_q   <= '0;
      mag_q   <= '0;
      neg_q   <= 1'b0;
      ch_q    <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (pop_o) begin
            ch_q  <= job_i.ch;
            neg_q <= job_i.neg;
            mag_q <= job_i.mag;
            if (job_i.div) begin
              dvd_q   <= dvd_init;
              den_q   <= job_i.den;
              rem_q   <= '0;
              quo_q   <= '0;
              step_q  <= '0;
              state_q <= ST_DIV;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          dvd_q  <= dvd_d;
          quo_q  <= quo_d;
          step_q <= step_q + 1'b1;
          if (step_q == sdcs_pkg::StepW'(sdcs_pkg::DivSteps - 1)) begin
            mag_q   <= (quo_d > sdcs_pkg::DvdW'(sdcs_pkg::ScaleTop))
                       ? sdcs_pkg::ScaleTop : quo_d[sdcs_pkg::SampleW-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/stick_deadzone_calibrate_scale.sv @@
// Top level of the stick dead zone, calibration and rescale block.
// Depends on sdcs_pkg, sdcs_if, sdcs_front, sdcs_fifo and sdcs_back.
//
// Samples for four 8-bit stick channels enter on in_i, results leave on out_o and
// registers are written through cfg_i, which is always ready. Calibrate and close
// items update the channel's rest band in the cycle of their transfer and give no
// result. A convert item is classified at once and queued (two entries); the back
// end then takes it, runs the serial divider, which produces two quotient bits per
// cycle, when a centred channel's sample lies below the band or above a band that
// ends under full scale, presents the result until it is taken and only then takes
// the next item.
`timescale 1ns / 1ps
`default_nettype none

module stick_deadzone_calibrate_scale (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sdcs_in_if.sink   in_i,
  sdcs_cfg_if.sink  cfg_i,
  sdcs_out_if.source out_o
);

  sdcs_pkg::job_t push_job;
  sdcs_pkg::job_t head_job;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;

  sdcs_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .job_o    (push_job),
    .push_o   (push)
  );

  sdcs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  sdcs_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (q_empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
